// File: sv/bds_pkg.sv
// shared types and constants for the box downsampler with row flip
// no dependencies
`default_nettype none

package bds_pkg;

  localparam int LANES    = 4;
  localparam int SAMP_W   = 8;
  localparam int IDX_W    = 12;
  localparam int IN_DW    = LANES * SAMP_W;
  localparam int OUT_DW   = 2 * IDX_W + LANES * SAMP_W;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 16;
  localparam int CH_W     = 3;
  localparam int QDEPTH   = 3;
  localparam int QPTR_W   = 2;

  localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_AW-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_CHANNEL_COUNT = 2'd2;

  typedef struct packed {
    logic             frame_end;
    logic [IDX_W-1:0] out_row;
    logic [IDX_W-1:0] out_column;
  } meta_t;

  typedef struct packed {
    logic  in_range;
    logic  first;
    logic  emit;
    meta_t meta;
  } s1_ctl_t;

  typedef logic [LANES-1:0][SAMP_W-1:0] lane_avg_t;

endpackage

`default_nettype wire

// File: sv/bds_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module bds_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/bds_lane.sv
// one channel lane: running block sum and truncating average
// depends on nothing but its parameter
`default_nettype none

module bds_lane #(
  parameter int SUM_W = 16
) (
  input  wire  [7:0]       sample,
  input  wire              first,
  input  wire  [SUM_W-1:0] prev_sum,
  input  wire  [3:0]       avg_shift,
  output logic [SUM_W-1:0] sum,
  output logic [7:0]       avg
);

  logic [SUM_W-1:0] shifted;

  always_comb begin
    sum     = first ? SUM_W'(sample) : prev_sum + SUM_W'(sample);
    shifted = sum >> avg_shift;
    avg     = shifted[7:0];
  end

endmodule

`default_nettype wire

// File: sv/bds_merge.sv
// merging stage: masks unused lanes, packs the result and queues it for output
// depends on bds_pkg
`default_nettype none

module bds_merge (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            push,
  input  wire  bds_pkg::meta_t           meta,
  input  wire  bds_pkg::lane_avg_t       lane_avg,
  input  wire  [bds_pkg::CH_W-1:0]       channel_count,
  output logic [bds_pkg::QPTR_W-1:0]     q_cnt,
  output logic                           out_tvalid,
  input  wire                            out_tready,
  output logic [bds_pkg::OUT_DW-1:0]     out_tdata,  // out_column, out_row, avg_0..avg_3
  output logic                           out_tlast   // frame_end
);
  import bds_pkg::*;

  logic [OUT_DW:0]      q_mem [QDEPTH];
  logic [QPTR_W-1:0]    wp_r, wp_nxt, rp_r, rp_nxt, cnt_r, cnt_nxt;
  lane_avg_t            masked;
  logic                 pop;

  localparam logic [QPTR_W-1:0] QLAST = QPTR_W'(QDEPTH - 1);

  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      masked[c] = (CH_W'(c) < channel_count) ? lane_avg[c] : '0;
    end
  end

  assign pop = out_tvalid && out_tready;

  always_comb begin
    wp_nxt  = push ? ((wp_r == QLAST) ? '0 : wp_r + 1'b1) : wp_r;
    rp_nxt  = pop ? ((rp_r == QLAST) ? '0 : rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + QPTR_W'(push) - QPTR_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wp_r] <= {meta.frame_end, masked, meta.out_row, meta.out_column};
    end
  end

  assign q_cnt      = cnt_r;
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = q_mem[rp_r][OUT_DW-1:0];
  assign out_tlast  = q_mem[rp_r][OUT_DW];

endmodule

`default_nettype wire

// File: sv/box_downsample_flip_rows.sv
// power-of-two box downsampler with vertical row flip, top level
// uses bds_pkg, bds_ram, bds_lane and bds_merge
//
// usage: source pixels enter on in_* in raster order, one per transfer, four
// channel bytes in in_tdata. image_width, image_height and channel_count are
// written on cfg_* while the block is idle; the scale is chosen from them at
// the write edge. each whole scale-by-scale block gives one result on
// out_*: column, flipped row and four truncated averages, out_tlast on the
// last block of the frame. partial edge blocks give nothing.
// a result passes the stage 1 registers and then the output queue before it
// is offered. throughput: one pixel per cycle while in_tready is high, set by
// the single read-modify-write per pixel on the column-sum ram (one read
// port, one write port, last write forwarded to the next pixel).
// a three-entry output queue decouples the sides; in_tready drops whenever
// the queued entries plus the pixel in stage 1 reach the queue depth.
// reset (rst_n low, synchronous) sets width and height to 1, channel count
// to 3 and the pixel position to the frame origin. ram contents need no
// clearing: the first pixel of each block overwrites its column entry.
`default_nettype none

module box_downsample_flip_rows #(
  parameter int MAX_OUT_DIM    = 4096,
  parameter int MAX_SCALE_LOG2 = 4
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            cfg_we,
  input  wire  [bds_pkg::CFG_AW-1:0]     cfg_index,
  input  wire  [bds_pkg::CFG_DW-1:0]     cfg_wdata,
  input  wire                            in_tvalid,
  output logic                           in_tready,
  input  wire  [bds_pkg::IN_DW-1:0]      in_tdata,   // sample_0, sample_1, sample_2, sample_3
  output logic                           out_tvalid,
  input  wire                            out_tready,
  output logic [bds_pkg::OUT_DW-1:0]     out_tdata,  // out_column, out_row, avg_0..avg_3
  output logic                           out_tlast   // frame_end
);
  import bds_pkg::*;

  localparam int DIM_W  = $clog2(MAX_OUT_DIM + 1);
  localparam int COL_W  = $clog2(MAX_OUT_DIM);
  localparam int SUM_W  = SAMP_W + 2 * MAX_SCALE_LOG2;
  localparam int RAM_W  = LANES * SUM_W;

  logic [15:0]      width_r, width_nxt, height_r, height_nxt;
  logic [CH_W-1:0]  chan_r, chan_nxt;
  logic [2:0]       scale_r, scale_nxt;
  logic [DIM_W-1:0] outw_r, outw_nxt, outh_r, outh_nxt;
  logic [31:0]      ow_full, oh_full;

  // configuration and scale choice
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    chan_nxt   = chan_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:   width_nxt  = cfg_wdata;
        REG_IMAGE_HEIGHT:  height_nxt = cfg_wdata;
        REG_CHANNEL_COUNT: chan_nxt   = cfg_wdata[CH_W-1:0];
        default: ;
      endcase
    end
    scale_nxt = '0;
    for (int k = 0; k < MAX_SCALE_LOG2; k++) begin
      if (((32'(width_nxt) >> scale_nxt) > 32'(MAX_OUT_DIM)) ||
          ((32'(height_nxt) >> scale_nxt) > 32'(MAX_OUT_DIM))) begin
        scale_nxt = scale_nxt + 3'd1;
      end
    end
    ow_full  = 32'(width_nxt) >> scale_nxt;
    oh_full  = 32'(height_nxt) >> scale_nxt;
    outw_nxt = (ow_full > 32'(MAX_OUT_DIM)) ? DIM_W'(MAX_OUT_DIM) : DIM_W'(ow_full);
    outh_nxt = (oh_full > 32'(MAX_OUT_DIM)) ? DIM_W'(MAX_OUT_DIM) : DIM_W'(oh_full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 16'd1;
      height_r <= 16'd1;
      chan_r   <= CH_W'(3);
      scale_r  <= '0;
      outw_r   <= DIM_W'(1);
      outh_r   <= DIM_W'(1);
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      chan_r   <= chan_nxt;
      scale_r  <= scale_nxt;
      outw_r   <= outw_nxt;
      outh_r   <= outh_nxt;
    end
  end

  // pixel position and block decode
  logic [15:0] x_r, x_nxt, y_r, y_nxt;
  logic [15:0] msk, bcol, brow, orow, ow16, oh16;
  logic        in_acc, in_range, first, last, fend;
  s1_ctl_t     s0_ctl;

  assign in_acc = in_tvalid && in_tready;

  always_comb begin
    ow16     = 16'(outw_r);
    oh16     = 16'(outh_r);
    msk      = ~(16'hFFFF << scale_r);
    bcol     = x_r >> scale_r;
    brow     = y_r >> scale_r;
    in_range = (bcol < ow16) && (brow < oh16);
    first    = ((x_r & msk) == 16'd0) && ((y_r & msk) == 16'd0);
    last     = ((x_r & msk) == msk) && ((y_r & msk) == msk);
    orow     = oh16 - 16'd1 - brow;
    fend     = (bcol == ow16 - 16'd1) && (brow == oh16 - 16'd1);
    s0_ctl.in_range        = in_range;
    s0_ctl.first           = first;
    s0_ctl.emit            = in_range && last;
    s0_ctl.meta.frame_end  = fend;
    s0_ctl.meta.out_row    = orow[IDX_W-1:0];
    s0_ctl.meta.out_column = bcol[IDX_W-1:0];

    x_nxt = x_r;
    y_nxt = y_r;
    if (in_acc) begin
      if ((17'(x_r) + 17'd1) >= 17'(width_r)) begin
        x_nxt = '0;
        y_nxt = ((17'(y_r) + 17'd1) >= 17'(height_r)) ? 16'd0 : y_r + 16'd1;
      end else begin
        x_nxt = x_r + 16'd1;
      end
    end
  end

  // stage 1: lanes accumulate against the ram entry
  logic             s1_valid_r;
  s1_ctl_t          s1_ctl_r;
  logic [COL_W-1:0] s1_addr_r;
  logic [IN_DW-1:0] s1_samp_r;
  logic             wr_valid_r;
  logic [COL_W-1:0] wr_addr_r;
  logic [RAM_W-1:0] wr_data_r;
  logic [RAM_W-1:0] ram_rdata, prev_sums, new_sums;
  logic             ram_we, s1_push;
  lane_avg_t        lane_avg;
  logic [QPTR_W-1:0] q_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r        <= '0;
      y_r        <= '0;
      s1_valid_r <= 1'b0;
      wr_valid_r <= 1'b0;
    end else begin
      x_r        <= x_nxt;
      y_r        <= y_nxt;
      s1_valid_r <= in_acc;
      wr_valid_r <= ram_we;
    end
  end

  always_ff @(posedge clk) begin
    s1_ctl_r  <= s0_ctl;
    s1_addr_r <= bcol[COL_W-1:0];
    s1_samp_r <= in_tdata;
    wr_addr_r <= s1_addr_r;
    wr_data_r <= new_sums;
  end

  // forward the previous cycle's write, the ram read missed it
  assign prev_sums = (wr_valid_r && (wr_addr_r == s1_addr_r)) ? wr_data_r : ram_rdata;
  assign ram_we    = s1_valid_r && s1_ctl_r.in_range;
  assign s1_push   = s1_valid_r && s1_ctl_r.emit;

  bds_ram #(
    .WIDTH(RAM_W),
    .DEPTH(MAX_OUT_DIM)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(s1_addr_r),
    .wdata(new_sums),
    .raddr(bcol[COL_W-1:0]),
    .rdata(ram_rdata)
  );

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    bds_lane #(
      .SUM_W(SUM_W)
    ) u_lane (
      .sample   (s1_samp_r[g*SAMP_W +: SAMP_W]),
      .first    (s1_ctl_r.first),
      .prev_sum (prev_sums[g*SUM_W +: SUM_W]),
      .avg_shift({scale_r, 1'b0}),
      .sum      (new_sums[g*SUM_W +: SUM_W]),
      .avg      (lane_avg[g])
    );
  end

  bds_merge u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (s1_push),
    .meta         (s1_ctl_r.meta),
    .lane_avg     (lane_avg),
    .channel_count(chan_r),
    .q_cnt        (q_cnt),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast)
  );

  assign in_tready = (3'(q_cnt) + 3'(s1_valid_r)) < 3'(QDEPTH);

  // checks
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    s1_push |-> (q_cnt != QPTR_W'(QDEPTH)))
    else $error("output queue overflow");

  a_scale_limit: assert property (@(posedge clk) disable iff (!rst_n)
    32'(scale_r) <= 32'(MAX_SCALE_LOG2))
    else $error("scale beyond limit");

  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    s1_push |-> (16'(s1_ctl_r.meta.out_column) < 16'(outw_r) || outw_r > DIM_W'(4096)))
    else $error("result column outside output width");

endmodule

`default_nettype wire
